// File: sv/tcpr_pkg.sv
// ----------------------------------------------------------------------------
// tcpr_pkg
// Shared types, codes and helpers of the text cell pixel renderer.
// ----------------------------------------------------------------------------
package tcpr_pkg;

   // store depths (defaults of the top-level parameters)
   localparam int unsigned FONT_WORDS_DEF      = 512;
   localparam int unsigned PALETTE_ENTRIES_DEF = 64;

   // fixed field widths
   localparam int unsigned INDEX_W  = 9;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned COLOR_W  = 15;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned RGB_W    = 3 * CHAN_W;
   localparam int unsigned CELL_PIX = 32;
   localparam int unsigned PIX_W    = 5;
   localparam logic [PIX_W-1:0] PIX_LAST = 5'd31;

   localparam logic [WORD_W-1:0] BLINK_THRESHOLD_RESET = 16'd30;

   typedef enum logic [1:0] {
      FUNC_LOAD_FONT    = 2'd0,
      FUNC_LOAD_PALETTE = 2'd1,
      FUNC_RENDER       = 2'd2
   } func_type;

   typedef enum logic [0:0] {
      CSR_DISPLAY_ENABLE  = 1'b0,
      CSR_BLINK_THRESHOLD = 1'b1
   } csr_index_type;

   // glyph words and colours of one cell, as read from the stores
   typedef struct packed {
      logic [WORD_W-1:0]  glyph0;
      logic [WORD_W-1:0]  glyph1;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic               blink;
   } lookup_type;

   // resolved cell: final colours and a row-major pixel mask
   typedef struct packed {
      logic [RGB_W-1:0]    fg_rgb;
      logic [RGB_W-1:0]    bg_rgb;
      logic [CELL_PIX-1:0] mask;
   } cell_type;

   // value modulo depth for value < 512, depth >= 2: eight compare/subtract steps
   function automatic logic [INDEX_W-1:0] wrap_index(input logic [INDEX_W-1:0] value,
                                                     input int unsigned depth);
      logic [INDEX_W-1:0] r;
      logic [16:0]        lim;
      r = value;
      for (int k = 7; k >= 0; k--) begin
         lim = 17'(depth) << k;
         if ({8'b0, r} >= lim) begin
            r = r - lim[INDEX_W-1:0];
         end
      end
      return r;
   endfunction

   // 5:5:5 colour to 8:8:8, black when the display is off
   function automatic logic [RGB_W-1:0] to_rgb(input logic [COLOR_W-1:0] c,
                                               input logic enable);
      logic [RGB_W-1:0] rgb;
      rgb = {c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
      return enable ? rgb : '0;
   endfunction

endpackage

// File: sv/tcpr_if.sv
// ----------------------------------------------------------------------------
// tcpr_req_if / tcpr_rsp_if
// Valid/ready channels of the text cell pixel renderer.
// ----------------------------------------------------------------------------
interface tcpr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [8:0]  table_index;
   logic [15:0] table_data;
   logic [15:0] text_word;
   logic        odd_column;
   logic [15:0] attribute;
   logic [15:0] blink_count;

   modport source (output valid, func, table_index, table_data, text_word,
                   odd_column, attribute, blink_count, input ready);
   modport sink   (input valid, func, table_index, table_data, text_word,
                   odd_column, attribute, blink_count, output ready);
endinterface

interface tcpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] pixel_x;
   logic [2:0] pixel_y;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_pixel;

   modport source (output valid, pixel_x, pixel_y, red, green, blue, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, red, green, blue, last_pixel,
                   output ready);
endinterface

// File: sv/tcpr_fetch.sv
// ----------------------------------------------------------------------------
// tcpr_fetch
// Takes items, writes the font and palette stores, reads glyph and colours.
// ----------------------------------------------------------------------------
module tcpr_fetch #(
   parameter int unsigned FONT_WORDS      = tcpr_pkg::FONT_WORDS_DEF,
   parameter int unsigned PALETTE_ENTRIES = tcpr_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tcpr_req_if.sink              req_ch,
   input  logic [15:0]           blink_threshold,
   output logic                  lookup_valid,
   input  logic                  lookup_ready,
   output tcpr_pkg::lookup_type  lookup
);

   localparam int unsigned FA_W = $clog2(FONT_WORDS);
   localparam int unsigned PA_W = $clog2(PALETTE_ENTRIES);
   localparam logic [9:0] FONT_LIMIT = 10'(FONT_WORDS);
   localparam logic [9:0] PAL_LIMIT  = 10'(PALETTE_ENTRIES);

   logic [15:0] font_mem [FONT_WORDS];
   logic [14:0] pal_mem  [PALETTE_ENTRIES];

   logic            s1_v_ff, s1_v_in;
   logic [FA_W-1:0] s1_ga0_ff, s1_ga1_ff;
   logic [PA_W-1:0] s1_fg_ff, s1_bg_ff;
   logic            s1_blink_ff;
   logic            s2_v_ff;
   tcpr_pkg::lookup_type lookup_ff;

   logic       accept, s1_free, s2_free;
   logic       is_font, is_pal, is_render;
   logic [7:0] code;
   logic [8:0] ga0, ga1, fg_idx, bg_idx;
   logic       blink_hit;

   assign s2_free = !s2_v_ff || lookup_ready;
   assign s1_free = !s1_v_ff || s2_free;
   assign req_ch.ready = s1_free;
   assign accept = req_ch.valid && req_ch.ready;

   assign is_font   = req_ch.func == tcpr_pkg::FUNC_LOAD_FONT;
   assign is_pal    = req_ch.func == tcpr_pkg::FUNC_LOAD_PALETTE;
   assign is_render = req_ch.func == tcpr_pkg::FUNC_RENDER;

   assign code   = req_ch.odd_column ? req_ch.text_word[15:8] : req_ch.text_word[7:0];
   assign ga0    = tcpr_pkg::wrap_index({code, 1'b0}, FONT_WORDS);
   assign ga1    = tcpr_pkg::wrap_index({code, 1'b1}, FONT_WORDS);
   assign fg_idx = tcpr_pkg::wrap_index({3'b000, req_ch.attribute[11:6]}, PALETTE_ENTRIES);
   assign bg_idx = tcpr_pkg::wrap_index({3'b000, req_ch.attribute[5:0]}, PALETTE_ENTRIES);
   assign blink_hit = req_ch.attribute[12] && (req_ch.blink_count > blink_threshold);
   assign s1_v_in = accept && is_render;

   // stage 1: wrapped addresses
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_free) begin
         s1_v_ff <= s1_v_in;
      end
      if (s1_free) begin
         s1_ga0_ff   <= ga0[FA_W-1:0];
         s1_ga1_ff   <= ga1[FA_W-1:0];
         s1_fg_ff    <= fg_idx[PA_W-1:0];
         s1_bg_ff    <= bg_idx[PA_W-1:0];
         s1_blink_ff <= blink_hit;
      end
   end

   // font and palette stores: one write port each, two registered read ports each
   always_ff @(posedge clock) begin
      if (accept && is_font && ({1'b0, req_ch.table_index} < FONT_LIMIT)) begin
         font_mem[req_ch.table_index[FA_W-1:0]] <= req_ch.table_data;
      end
      if (accept && is_pal && ({1'b0, req_ch.table_index} < PAL_LIMIT)) begin
         pal_mem[req_ch.table_index[PA_W-1:0]] <= req_ch.table_data[14:0];
      end
      if (s2_free) begin
         lookup_ff.glyph0 <= font_mem[s1_ga0_ff];
         lookup_ff.glyph1 <= font_mem[s1_ga1_ff];
         lookup_ff.fg     <= pal_mem[s1_fg_ff];
         lookup_ff.bg     <= pal_mem[s1_bg_ff];
         lookup_ff.blink  <= s1_blink_ff;
      end
   end

   // stage 2 valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_free) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   assign lookup_valid = s2_v_ff;
   assign lookup       = lookup_ff;

endmodule

// File: sv/tcpr_shade.sv
// ----------------------------------------------------------------------------
// tcpr_shade
// Resolves blink and display enable into final colours; lays out the mask.
// ----------------------------------------------------------------------------
module tcpr_shade (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 display_enable,
   input  logic                 lookup_valid,
   output logic                 lookup_ready,
   input  tcpr_pkg::lookup_type lookup,
   output logic                 cell_valid,
   input  logic                 cell_ready,
   output tcpr_pkg::cell_type   cell_data
);

   logic               cell_v_ff;
   tcpr_pkg::cell_type cell_ff, cell_in;
   logic               free;
   logic [14:0]        fg_col;

   assign free = !cell_v_ff || cell_ready;
   assign lookup_ready = free;
   assign fg_col = lookup.blink ? lookup.bg : lookup.fg;

   always_comb begin
      cell_in.fg_rgb = tcpr_pkg::to_rgb(fg_col, display_enable);
      cell_in.bg_rgb = tcpr_pkg::to_rgb(lookup.bg, display_enable);
      // row-major: bit y*4+x; even columns use the high byte of a glyph word
      for (int y = 0; y < 8; y++) begin
         cell_in.mask[y*4 + 0] = lookup.glyph0[8 + y];
         cell_in.mask[y*4 + 1] = lookup.glyph0[y];
         cell_in.mask[y*4 + 2] = lookup.glyph1[8 + y];
         cell_in.mask[y*4 + 3] = lookup.glyph1[y];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_v_ff <= 1'b0;
      end else if (free) begin
         cell_v_ff <= lookup_valid;
      end
      if (free) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_valid = cell_v_ff;
   assign cell_data  = cell_ff;

endmodule

// File: sv/tcpr_serializer.sv
// ----------------------------------------------------------------------------
// tcpr_serializer
// Walks a resolved cell pixel by pixel into the registered result channel.
// ----------------------------------------------------------------------------
module tcpr_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               cell_valid,
   output logic               cell_ready,
   input  tcpr_pkg::cell_type cell_data,
   tcpr_rsp_if.source         rsp_ch
);

   logic                         ser_v_ff;
   logic [tcpr_pkg::PIX_W-1:0]   cnt_ff;
   tcpr_pkg::cell_type           cell_ff;
   logic                         rsp_v_ff;
   logic [1:0]                   x_ff;
   logic [2:0]                   y_ff;
   logic [tcpr_pkg::RGB_W-1:0]   rgb_ff;
   logic                         last_ff;

   logic out_take, fire, at_last, ser_free;
   logic [tcpr_pkg::RGB_W-1:0] rgb_in;

   assign out_take = !rsp_v_ff || rsp_ch.ready;
   assign fire     = ser_v_ff && out_take;
   assign at_last  = cnt_ff == tcpr_pkg::PIX_LAST;
   assign ser_free = !ser_v_ff || (fire && at_last);
   assign cell_ready = ser_free;
   assign rgb_in = cell_ff.mask[cnt_ff] ? cell_ff.fg_rgb : cell_ff.bg_rgb;

   // next cell loads on the edge that sends the last pixel of the current one
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_v_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (ser_free) begin
         ser_v_ff <= cell_valid;
         cnt_ff   <= '0;
      end else if (fire) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (ser_free) begin
         cell_ff <= cell_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_take) begin
         rsp_v_ff <= fire;
      end
      if (fire) begin
         x_ff    <= cnt_ff[1:0];
         y_ff    <= cnt_ff[4:2];
         rgb_ff  <= rgb_in;
         last_ff <= at_last;
      end
   end

   assign rsp_ch.valid      = rsp_v_ff;
   assign rsp_ch.pixel_x    = x_ff;
   assign rsp_ch.pixel_y    = y_ff;
   assign rsp_ch.red        = rgb_ff[23:16];
   assign rsp_ch.green      = rgb_ff[15:8];
   assign rsp_ch.blue       = rgb_ff[7:0];
   assign rsp_ch.last_pixel = last_ff;

endmodule

// File: sv/text_cell_pixel_renderer.sv
// ----------------------------------------------------------------------------
// text_cell_pixel_renderer
// Text-mode character generator: renders one 4x8 cell into 32 RGB pixels.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | item
//  req_ch  | in  | valid/ready       | font load, palette load or render cell
//  rsp_ch  | out | valid/ready       | one pixel: x, y, red, green, blue, last
//  csr_*   | in  | csr_we, no ready  | register write (display enable, blink)
//
//  A render item yields 32 pixels, one per cycle while rsp_ch is ready; the
//  pixel serializer takes the next cell as it sends the last pixel of the
//  current one. Loads yield nothing.
//  Reset is synchronous and clears control state only; the stores are not
//  cleared. A stall on rsp_ch holds every stage in place and backs up to
//  req_ch.ready; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module text_cell_pixel_renderer #(
   parameter int unsigned FONT_WORDS      = tcpr_pkg::FONT_WORDS_DEF,
   parameter int unsigned PALETTE_ENTRIES = tcpr_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   tcpr_req_if.sink                req_ch,
   tcpr_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  tcpr_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);

   // configuration registers
   logic        display_enable_ff;
   logic [15:0] blink_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_enable_ff  <= 1'b0;
         blink_threshold_ff <= tcpr_pkg::BLINK_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tcpr_pkg::CSR_DISPLAY_ENABLE:  display_enable_ff  <= csr_wdata[0];
            tcpr_pkg::CSR_BLINK_THRESHOLD: blink_threshold_ff <= csr_wdata;
            default:                       display_enable_ff  <= display_enable_ff;
         endcase
      end
   end

   // stages 1-2: address wrap, store writes, store reads
   logic                 lookup_valid, lookup_ready;
   tcpr_pkg::lookup_type lookup;

   tcpr_fetch #(
      .FONT_WORDS      (FONT_WORDS),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_fetch (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .blink_threshold (blink_threshold_ff),
      .lookup_valid    (lookup_valid),
      .lookup_ready    (lookup_ready),
      .lookup          (lookup)
   );

   // stage 3: blink, enable, 5-to-8-bit widening, pixel mask
   logic               cell_valid, cell_ready;
   tcpr_pkg::cell_type cell_data;

   tcpr_shade u_shade (
      .clock          (clock),
      .reset          (reset),
      .display_enable (display_enable_ff),
      .lookup_valid   (lookup_valid),
      .lookup_ready   (lookup_ready),
      .lookup         (lookup),
      .cell_valid     (cell_valid),
      .cell_ready     (cell_ready),
      .cell_data      (cell_data)
   );

   // stage 4-5: per-pixel serializer and output register
   tcpr_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .cell_valid (cell_valid),
      .cell_ready (cell_ready),
      .cell_data  (cell_data),
      .rsp_ch     (rsp_ch)
   );

   logic [4:0] pix_idx;
   assign pix_idx = {rsp_ch.pixel_y, rsp_ch.pixel_x};

`ifndef SYNTHESIS
   // last flag marks exactly the bottom-right pixel
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.last_pixel == (pix_idx == 5'd31)))
      else $error("last_pixel out of place");

   // within a cell, pixels follow each other with no gap in row-major order
   a_pix_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_pixel
      |=> rsp_ch.valid && (pix_idx == $past(pix_idx) + 5'd1))
      else $error("pixel sequence broken");

   // a resolved cell waiting on the serializer holds
   a_cell_hold: assert property (@(posedge clock) disable iff (reset)
      cell_valid && !cell_ready |=> cell_valid && $stable(cell_data))
      else $error("cell changed while stalled");
`endif

endmodule

// File: tb/tb_text_cell_pixel_renderer.sv
// ----------------------------------------------------------------------------
// tb_text_cell_pixel_renderer
// Self-checking bench for the text cell pixel renderer: loads font and palette
// words, renders cells under several display/blink settings and checks every
// pixel against an in-bench prediction, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_text_cell_pixel_renderer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FONT_DEPTH   = tcpr_pkg::FONT_WORDS_DEF;
   localparam int unsigned PAL_DEPTH    = tcpr_pkg::PALETTE_ENTRIES_DEF;
   localparam int          IDLE_LIMIT   = 2000;  // cycles with no handshake at all
   localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int          DRAIN_CYCLES = 20;    // pipeline is 5 deep, pad generously
   localparam int          PHASE_ITEMS  = 20;    // random items per register setting
   localparam logic [1:0]  FUNC_UNUSED  = 2'd3;  // function code with no meaning

   // one request item as driven on req_ch
   typedef struct packed {
      logic [1:0]  func;
      logic [8:0]  table_index;
      logic [15:0] table_data;
      logic [15:0] text_word;
      logic        odd_column;
      logic [15:0] attribute;
      logic [15:0] blink_count;
   } req_item_type;

   // one pixel item as seen on rsp_ch
   typedef struct packed {
      logic [1:0] pixel_x;
      logic [2:0] pixel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } pixel_item_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the stores and registers, expands each accepted
   // render into its 32 pixels and matches them in order against the output.
   // -------------------------------------------------------------------------
   class pixel_scoreboard;
      pixel_item_type pending_pixels[$];
      logic [15:0]    font_mem[FONT_DEPTH];
      logic [14:0]    pal_mem[PAL_DEPTH];
      logic           disp_en;
      logic [15:0]    blink_thr;
      int             errors;
      int             checked;
      int             renders;
      int             loads;
      int             ignored;

      function new();
         disp_en   = 1'b0;
         blink_thr = tcpr_pkg::BLINK_THRESHOLD_RESET;
      endfunction

      function void set_register(tcpr_pkg::csr_index_type idx, logic [15:0] data);
         if (idx == tcpr_pkg::CSR_DISPLAY_ENABLE) begin
            disp_en = data[0];
         end else begin
            blink_thr = data;
         end
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function void note_request(req_item_type r);
         logic [7:0]     code;
         logic [14:0]    fg;
         logic [14:0]    bg;
         logic [14:0]    col;
         logic [15:0]    g0;
         logic [15:0]    g1;
         logic [15:0]    word;
         logic           dot;
         pixel_item_type p;
         if (r.func == tcpr_pkg::FUNC_LOAD_FONT) begin
            font_mem[r.table_index] = r.table_data;
            loads++;
         end else if (r.func == tcpr_pkg::FUNC_LOAD_PALETTE) begin
            // out-of-range palette writes are dropped
            if (r.table_index < PAL_DEPTH) begin
               pal_mem[r.table_index[5:0]] = r.table_data[14:0];
               loads++;
            end else begin
               ignored++;
            end
         end else if (r.func == tcpr_pkg::FUNC_RENDER) begin
            renders++;
            code = r.odd_column ? r.text_word[15:8] : r.text_word[7:0];
            fg   = pal_mem[r.attribute[11:6]];
            bg   = pal_mem[r.attribute[5:0]];
            if (r.blink_count > blink_thr && r.attribute[12]) begin
               fg = bg;
            end
            g0 = font_mem[{code, 1'b0}];
            g1 = font_mem[{code, 1'b1}];
            for (int y = 0; y < 8; y++) begin
               for (int x = 0; x < 4; x++) begin
                  word = (x < 2) ? g0 : g1;
                  dot  = (x % 2 == 0) ? word[8 + y] : word[y];
                  col  = dot ? fg : bg;
                  p.pixel_x    = 2'(x);
                  p.pixel_y    = 3'(y);
                  p.red        = disp_en ? {col[14:10], 3'b000} : 8'd0;
                  p.green      = disp_en ? {col[9:5], 3'b000} : 8'd0;
                  p.blue       = disp_en ? {col[4:0], 3'b000} : 8'd0;
                  p.last_pixel = (x == 3 && y == 7);
                  pending_pixels.push_back(p);
               end
            end
         end else begin
            ignored++;
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: pixel %0d field %s expected %0d actual %0d",
                     $time, checked, name, want, got);
            errors++;
         end
      endfunction

      function void check_pixel(pixel_item_type got);
         pixel_item_type want;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d rgb=%0d/%0d/%0d last=%0d",
                     $time, got.pixel_x, got.pixel_y, got.red, got.green, got.blue,
                     got.last_pixel);
            errors++;
            return;
         end
         want = pending_pixels.pop_front();
         compare_field("pixel_x", want.pixel_x, got.pixel_x);
         compare_field("pixel_y", want.pixel_y, got.pixel_y);
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
         compare_field("last_pixel", want.last_pixel, got.last_pixel);
         checked++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its channels
   // -------------------------------------------------------------------------
   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   tcpr_pkg::csr_index_type csr_index;
   logic [15:0]             csr_wdata;

   tcpr_req_if req_ch();
   tcpr_rsp_if rsp_ch();

   text_cell_pixel_renderer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_scoreboard sb;

   // stimulus-side bookkeeping: which glyphs and colours may be read
   bit          font_loaded[FONT_DEPTH];
   bit          glyph_listed[256];
   bit          pal_loaded[PAL_DEPTH];
   logic [7:0]  glyph_chars[$];
   logic [5:0]  colors[$];
   logic [15:0] cur_thr;
   int          settings_seen;
   bit          stall_request;
   bit          stall_done;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: handshakes are sampled at the edge, before any NBA lands.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_request({req_ch.func, req_ch.table_index, req_ch.table_data,
                             req_ch.text_word, req_ch.odd_column, req_ch.attribute,
                             req_ch.blink_count});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_pixel({rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.red, rsp_ch.green,
                            rsp_ch.blue, rsp_ch.last_pixel});
         end
      end
   end

   // Watchdog: ends the run as failed once its idle counter, cleared by any
   // handshake on either channel, reaches IDLE_LIMIT. Covers the long hold-off, gaps and phase changes.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(12, 48);
   endfunction

   // -------------------------------------------------------------------------
   // Receiver: runs of ready high broken by random gaps; once asked, it
   // holds ready low through one long hold-off so the pipeline fills and req_ch stalls.
   // -------------------------------------------------------------------------
   initial begin
      int run;
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_request && !stall_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_done = 1'b1;
         end
         run = $urandom_range(1, 40);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = idle_len();
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------

   // Offer one item and hold it until accepted. With no gap the valid stays
   // high into the next item, so it is never lowered and raised in one step.
   task automatic send_req(input req_item_type it);
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.func        <= it.func;
      req_ch.table_index <= it.table_index;
      req_ch.table_data  <= it.table_data;
      req_ch.text_word   <= it.text_word;
      req_ch.odd_column  <= it.odd_column;
      req_ch.attribute   <= it.attribute;
      req_ch.blink_count <= it.blink_count;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      gap = idle_len();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Track which entries have been written so renders only read those, then send.
   task automatic offer(input req_item_type it);
      logic [7:0] c;
      if (it.func == tcpr_pkg::FUNC_LOAD_FONT) begin
         font_loaded[it.table_index] = 1'b1;
         c = it.table_index[8:1];
         if (font_loaded[{c, 1'b0}] && font_loaded[{c, 1'b1}] && !glyph_listed[c]) begin
            glyph_listed[c] = 1'b1;
            glyph_chars.push_back(c);
         end
      end else if (it.func == tcpr_pkg::FUNC_LOAD_PALETTE && it.table_index < PAL_DEPTH) begin
         if (!pal_loaded[it.table_index]) begin
            pal_loaded[it.table_index] = 1'b1;
            colors.push_back(it.table_index[5:0]);
         end
      end
      send_req(it);
   endtask

   // Register writes only happen while the block is idle; each one lowers csr_we
   // again before returning, so two NBAs never stack on csr_we in one step.
   task automatic write_csr(input tcpr_pkg::csr_index_type idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      sb.set_register(idx, data);
      if (idx == tcpr_pkg::CSR_BLINK_THRESHOLD) cur_thr = data;
      settings_seen++;
   endtask

   // Drop valid, wait for every pixel, then let loads still in flight settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_item_type make_item(logic [1:0] func, logic [8:0] idx,
                                              logic [15:0] data, logic [15:0] text,
                                              logic odd, logic [15:0] attr,
                                              logic [15:0] blink);
      return {func, idx, data, text, odd, attr, blink};
   endfunction

   function automatic req_item_type rand_item();
      return {2'($urandom_range(0, 3)), 9'($urandom), 16'($urandom), 16'($urandom),
              1'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   // Render of a loaded glyph with loaded colours; unread fields stay random.
   function automatic req_item_type rand_render();
      req_item_type it;
      logic [7:0]   code;
      logic [7:0]   other;
      it        = rand_item();
      it.func   = tcpr_pkg::FUNC_RENDER;
      code      = glyph_chars[$urandom_range(0, glyph_chars.size() - 1)];
      other     = 8'($urandom);
      it.text_word = it.odd_column ? {code, other} : {other, code};
      it.attribute[11:6] = colors[$urandom_range(0, colors.size() - 1)];
      it.attribute[5:0]  = colors[$urandom_range(0, colors.size() - 1)];
      case ($urandom_range(0, 3))
         0: it.blink_count = cur_thr;          // just at the threshold: no blink
         1: it.blink_count = cur_thr + 16'd1;  // just above it
         default: ;
      endcase
      return it;
   endfunction

   // Random traffic: mostly glyph loads followed by renders of what is loaded,
   // plus stray single font words, palette updates and junk codes.
   task automatic run_random(input int n, input bit with_hold);
      int           done;
      int           r;
      logic [7:0]   c;
      req_item_type it;
      done = 0;
      while (done < n) begin
         if (with_hold && done >= 4) stall_request = 1'b1;
         r  = $urandom_range(0, 99);
         it = rand_item();
         if (r < 20) begin
            c = 8'($urandom);
            it.func = tcpr_pkg::FUNC_LOAD_FONT;
            it.table_index = {c, 1'b0};
            offer(it);
            it = rand_item();
            it.func = tcpr_pkg::FUNC_LOAD_FONT;
            it.table_index = {c, 1'b1};
            offer(it);
            done += 2;
         end else if (r < 28) begin
            it.func = tcpr_pkg::FUNC_LOAD_FONT;
            offer(it);
            done++;
         end else if (r < 40) begin
            it.func = tcpr_pkg::FUNC_LOAD_PALETTE;
            if ($urandom_range(0, 4) != 0) begin
               it.table_index = 9'($urandom_range(0, PAL_DEPTH - 1));
               done++;
            end else begin
               it.table_index = 9'($urandom_range(PAL_DEPTH, 511));
            end
            offer(it);
         end else if (r < 94) begin
            offer(rand_render());
            done++;
         end else begin
            it.func = FUNC_UNUSED;
            offer(it);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      cur_thr       = tcpr_pkg::BLINK_THRESHOLD_RESET;
      settings_seen = 1;
      stall_request = 1'b0;
      stall_done    = 1'b0;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= tcpr_pkg::CSR_DISPLAY_ENABLE;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= tcpr_pkg::FUNC_LOAD_FONT;
      req_ch.table_index <= '0;
      req_ch.table_data  <= '0;
      req_ch.text_word   <= '0;
      req_ch.odd_column  <= 1'b0;
      req_ch.attribute   <= '0;
      req_ch.blink_count <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset registers (display off, threshold 30).
      // Glyphs for char 0, char 255 and char 0x81.
      offer(make_item(tcpr_pkg::FUNC_LOAD_FONT, 9'd0, 16'h0000,
                      16'h0000, 1'b0, 16'h0000, 16'h0000));
      offer(make_item(tcpr_pkg::FUNC_LOAD_FONT, 9'd1, 16'hFFFF,
                      16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
      offer(make_item(tcpr_pkg::FUNC_LOAD_FONT, 9'd510, 16'hA55A,
                      16'h0000, 1'b0, 16'h0000, 16'h0000));
      offer(make_item(tcpr_pkg::FUNC_LOAD_FONT, 9'd511, 16'h5AA5,
                      16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
      offer(make_item(tcpr_pkg::FUNC_LOAD_FONT, 9'd258, 16'h1234,
                      16'h5555, 1'b0, 16'hAAAA, 16'h5555));
      offer(make_item(tcpr_pkg::FUNC_LOAD_FONT, 9'd259, 16'hFEDC,
                      16'hAAAA, 1'b1, 16'h5555, 16'hAAAA));
      // palette: bit 15 of the data must be dropped, pure channels, black
      offer(make_item(tcpr_pkg::FUNC_LOAD_PALETTE, 9'd0, 16'hFFFF,
                      16'h0000, 1'b0, 16'h0000, 16'h0000));
      offer(make_item(tcpr_pkg::FUNC_LOAD_PALETTE, 9'd63, 16'h0000,
                      16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
      offer(make_item(tcpr_pkg::FUNC_LOAD_PALETTE, 9'd21, 16'h7C00,
                      16'h0000, 1'b0, 16'h0000, 16'h0000));
      offer(make_item(tcpr_pkg::FUNC_LOAD_PALETTE, 9'd42, 16'h03E0,
                      16'h0000, 1'b0, 16'h0000, 16'h0000));
      offer(make_item(tcpr_pkg::FUNC_LOAD_PALETTE, 9'd5, 16'h801F,
                      16'h0000, 1'b0, 16'h0000, 16'h0000));
      // palette writes past the end are dropped, not wrapped onto 0 or 63
      offer(make_item(tcpr_pkg::FUNC_LOAD_PALETTE, 9'd64, 16'h1234,
                      16'h0000, 1'b0, 16'h0000, 16'h0000));
      offer(make_item(tcpr_pkg::FUNC_LOAD_PALETTE, 9'd511, 16'h4321,
                      16'h0000, 1'b0, 16'h0000, 16'h0000));
      // unused function code: no pixels
      offer(make_item(FUNC_UNUSED, 9'd511, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
      // display off: 32 black pixels, char 0 from the low byte
      offer(make_item(tcpr_pkg::FUNC_RENDER, 9'd0, 16'h0000,
                      16'hFF00, 1'b0, 16'h0FFF, 16'h0000));

      drain();
      write_csr(tcpr_pkg::CSR_DISPLAY_ENABLE, 16'h0001);
      // char 255 from the high byte; blink bit set, count at and above 30
      offer(make_item(tcpr_pkg::FUNC_RENDER, 9'd0, 16'h0000,
                      16'hFF00, 1'b1, 16'h156A, 16'd30));
      offer(make_item(tcpr_pkg::FUNC_RENDER, 9'd0, 16'h0000,
                      16'hFF00, 1'b1, 16'h156A, 16'd31));
      // char 0x81, fg 5 bg 0, unused attribute bits high, blink bit clear
      offer(make_item(tcpr_pkg::FUNC_RENDER, 9'h1FF, 16'hFFFF,
                      16'h8137, 1'b1, 16'hE140, 16'hFFFF));
      // char 255 from the low byte, every attribute bit set
      offer(make_item(tcpr_pkg::FUNC_RENDER, 9'd0, 16'h0000,
                      16'h00FF, 1'b0, 16'hFFFF, 16'h0000));

      drain();
      write_csr(tcpr_pkg::CSR_BLINK_THRESHOLD, 16'h0000);
      offer(make_item(tcpr_pkg::FUNC_RENDER, 9'd0, 16'h0000,
                      16'h0001, 1'b1, 16'h1555, 16'd0));
      offer(make_item(tcpr_pkg::FUNC_RENDER, 9'd0, 16'h0000,
                      16'h0001, 1'b1, 16'h1555, 16'd1));

      drain();
      write_csr(tcpr_pkg::CSR_BLINK_THRESHOLD, 16'hFFFF);
      // nothing can exceed the top threshold
      offer(make_item(tcpr_pkg::FUNC_RENDER, 9'd0, 16'h0000,
                      16'h81FF, 1'b0, 16'h1FC0, 16'hFFFF));

      // Random phases, each under its own register setting. The second one
      // carries the long receiver hold-off.
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: begin
               write_csr(tcpr_pkg::CSR_DISPLAY_ENABLE, {15'($urandom), 1'b1});
               write_csr(tcpr_pkg::CSR_BLINK_THRESHOLD, 16'($urandom));
            end
            1: begin
               write_csr(tcpr_pkg::CSR_DISPLAY_ENABLE, {15'($urandom), 1'b1});
               write_csr(tcpr_pkg::CSR_BLINK_THRESHOLD, 16'h0000);
            end
            2: begin
               write_csr(tcpr_pkg::CSR_DISPLAY_ENABLE, {15'($urandom), 1'b0});
               write_csr(tcpr_pkg::CSR_BLINK_THRESHOLD, tcpr_pkg::BLINK_THRESHOLD_RESET);
            end
            default: begin
               write_csr(tcpr_pkg::CSR_DISPLAY_ENABLE, {15'($urandom), 1'b1});
               write_csr(tcpr_pkg::CSR_BLINK_THRESHOLD, 16'($urandom_range(0, 64)));
            end
         endcase
         run_random(PHASE_ITEMS, ph == 1);
      end

      drain();
      $display("Covered %0d cell renders, %0d table loads, %0d ignored items and %0d pixels",
               sb.renders, sb.loads, sb.ignored, sb.checked);
      $display("over %0d register settings, %0d mismatches", settings_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
